// ===== design/aarm_pkg.sv =====
// Shared constants and types for the axis-angle rotation matrix pipeline.
// No dependencies; every other design file imports this package.
package aarm_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int TRIG_STAGES_DEF = 18;

  // Angles in Q16.16 degrees, 34-bit unsigned working width
  localparam logic [33:0] DEG_FULL    = 34'd23592960;
  localparam logic [33:0] DEG_HALF    = 34'd11796480;
  localparam logic [33:0] DEG_QUARTER = 34'd5898240;

  // pi/180 in Q.44, split into 19-bit high and 20-bit low partial products
  localparam logic [38:0] PI_Q44 = 39'd307041569098;
  localparam logic [18:0] PI_HI  = PI_Q44[38:20];
  localparam logic [19:0] PI_LO  = PI_Q44[19:0];

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam int OUT_ONE = 65536;

  // atan(2^-i) in Q2.30 radians, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

endpackage

// ===== design/aarm_angle.sv =====
// Angle front end: modulo-360 reduction, quadrant fold and degree-to-radian scaling.
// Depends on aarm_pkg. Five register stages, advanced by the shared enable.
module aarm_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] angle_deg,
  input  aarm_pkg::axis_t    axis_in,
  output logic               out_valid,
  output logic [31:0]        rad,
  output logic               neg_out,
  output logic               mirror_out,
  output aarm_pkg::axis_t    axis_out
);
  import aarm_pkg::*;

  localparam int RW = 34;

  logic [RW-1:0] r1, r1_next;
  logic [24:0]   r2, r2_next;
  logic [22:0]   mag3, mag3_next;
  logic          neg3, neg3_next, mir3, mir3_next;
  logic [41:0]   phi, phi_next;
  logic [42:0]   plo, plo_next;
  logic [31:0]   rad_next;
  logic          neg4, mir4;
  logic          v1, v2, v3, v4;
  axis_t         a1, a2, a3, a4;

  // Bias positive, then strip multiples of 360 degrees, four per stage
  always_comb begin
    logic [RW-1:0] t;
    t = RW'(angle_deg) + (DEG_FULL << 7);
    for (int k = 7; k >= 4; k--) begin
      if (t >= (DEG_FULL << k)) t = t - (DEG_FULL << k);
    end
    r1_next = t;
  end

  always_comb begin
    logic [RW-1:0] t;
    t = r1;
    for (int k = 3; k >= 0; k--) begin
      if (t >= (DEG_FULL << k)) t = t - (DEG_FULL << k);
    end
    r2_next = t[24:0];
  end

  // Fold to [0, 90] degrees
  always_comb begin
    logic [24:0] m;
    neg3_next = r2 >= DEG_HALF[24:0];
    m = neg3_next ? (DEG_FULL[24:0] - r2) : r2;
    mir3_next = m > DEG_QUARTER[24:0];
    mag3_next = mir3_next ? 23'(DEG_HALF[24:0] - m) : m[22:0];
  end

  assign phi_next = {19'b0, mag3} * {23'b0, PI_HI};
  assign plo_next = {20'b0, mag3} * {23'b0, PI_LO};

  always_comb begin
    logic [61:0] sum;
    sum = {phi, 20'b0} + 62'(plo) + (62'(1) << 29);
    rad_next = 32'(sum >> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
      r1 <= r1_next;
      a1 <= axis_in;
      r2 <= r2_next;
      a2 <= a1;
      mag3 <= mag3_next;
      neg3 <= neg3_next;
      mir3 <= mir3_next;
      a3 <= a2;
      phi <= phi_next;
      plo <= plo_next;
      neg4 <= neg3;
      mir4 <= mir3;
      a4 <= a3;
      rad <= rad_next;
      neg_out <= neg4;
      mirror_out <= mir4;
      axis_out <= a4;
    end
  end

endmodule

// ===== design/aarm_cordic.sv =====
// Rotation-mode CORDIC, one iteration per register stage, plus a rounding stage.
// Depends on aarm_pkg.
module aarm_cordic #(
  parameter int STAGES = aarm_pkg::TRIG_STAGES_DEF,
  parameter int FB     = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        rad,
  input  logic               neg_in,
  input  logic               mirror_in,
  input  aarm_pkg::axis_t    axis_in,
  output logic               out_valid,
  output logic signed [FB+1:0] cos_out,
  output logic signed [FB+1:0] sin_out,
  output aarm_pkg::axis_t    axis_out
);
  import aarm_pkg::*;

  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int CW = FB + 2;
  localparam int RS = 30 - FB;

  logic signed [XW-1:0] xs [STAGES];
  logic signed [XW-1:0] ys [STAGES];
  logic signed [ZW-1:0] zs [STAGES];
  logic                 vs [STAGES];
  logic                 ns [STAGES];
  logic                 ms [STAGES];
  axis_t                as_ [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic                 vi, ni, mi;
    axis_t                ai;

    if (i == 0) begin : g_first
      assign xi = {2'b00, CORDIC_GAIN_Q30};
      assign yi = '0;
      assign zi = {1'b0, rad};
      assign vi = in_valid;
      assign ni = neg_in;
      assign mi = mirror_in;
      assign ai = axis_in;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign vi = vs[i-1];
      assign ni = ns[i-1];
      assign mi = ms[i-1];
      assign ai = as_[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else if (en) begin
        vs[i] <= vi;
        ns[i] <= ni;
        ms[i] <= mi;
        as_[i] <= ai;
        if (zi >= 0) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - ZW'(ATAN_Q30[i]);
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + ZW'(ATAN_Q30[i]);
        end
      end
    end
  end

  logic signed [XW-1:0] xr, yr;

  if (RS > 0) begin : g_round
    assign xr = (xs[STAGES-1] + (XW'(1) << (RS - 1))) >>> RS;
    assign yr = (ys[STAGES-1] + (XW'(1) << (RS - 1))) >>> RS;
  end else begin : g_exact
    assign xr = xs[STAGES-1];
    assign yr = ys[STAGES-1];
  end

  logic signed [CW-1:0] cos_next, sin_next;
  assign cos_next = ms[STAGES-1] ? -CW'(xr) : CW'(xr);
  assign sin_next = ns[STAGES-1] ? -CW'(yr) : CW'(yr);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[STAGES-1];
      cos_out <= cos_next;
      sin_out <= sin_next;
      axis_out <= as_[STAGES-1];
    end
  end

endmodule

// ===== design/aarm_norm.sv =====
// Axis normalization: squared length, bit-per-stage square root, then three
// restoring dividers with one quotient bit per stage. Depends on aarm_pkg.
module aarm_norm #(
  parameter int FB = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [FB+1:0] cos_in,
  input  logic signed [FB+1:0] sin_in,
  input  aarm_pkg::axis_t      axis_in,
  output logic                 out_valid,
  output logic signed [FB+1:0] ux,
  output logic signed [FB+1:0] uy,
  output logic signed [FB+1:0] uz,
  output logic signed [FB+1:0] cos_out,
  output logic signed [FB+1:0] sin_out,
  output logic                 zero_out
);
  import aarm_pkg::*;

  localparam int CW = FB + 2;
  localparam int SW = 62;
  localparam int SQ = 31;
  localparam int NW = FB + 32;
  localparam int QB = FB + 1;

  typedef struct packed {
    logic [2:0][15:0]     mag;
    logic [2:0]           sgn;
    logic                 zero;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } carry_t;

  // Squared length
  logic [31:0] la, la_next;
  carry_t      ca, ca_next;
  logic        va;

  always_comb begin
    logic signed [31:0] qx, qy, qz;
    qx = axis_in.x * axis_in.x;
    qy = axis_in.y * axis_in.y;
    qz = axis_in.z * axis_in.z;
    la_next = 32'(qx) + 32'(qy) + 32'(qz);
    ca_next.mag[0] = axis_in.x[15] ? 16'(-axis_in.x) : axis_in.x;
    ca_next.mag[1] = axis_in.y[15] ? 16'(-axis_in.y) : axis_in.y;
    ca_next.mag[2] = axis_in.z[15] ? 16'(-axis_in.z) : axis_in.z;
    ca_next.sgn = {axis_in.z[15], axis_in.y[15], axis_in.x[15]};
    ca_next.zero = (axis_in.x == 0) && (axis_in.y == 0) && (axis_in.z == 0);
    ca_next.c = cos_in;
    ca_next.s = sin_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      la <= la_next;
      ca <= ca_next;
    end
  end

  // Square root of L * 2^30, one result bit per stage
  logic [SW-1:0] sn [SQ];
  logic [SW-1:0] sr [SQ];
  carry_t        sc [SQ];
  logic          sv [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [SW-1:0] ni, ri, nn, rn, t;
    carry_t        ci;
    logic          vi;

    if (k == 0) begin : g_first
      assign ni = {la, 30'b0};
      assign ri = '0;
      assign ci = ca;
      assign vi = va;
    end else begin : g_rest
      assign ni = sn[k-1];
      assign ri = sr[k-1];
      assign ci = sc[k-1];
      assign vi = sv[k-1];
    end

    assign t = ri + (SW'(1) << (60 - 2 * k));

    always_comb begin
      if (ni >= t) begin
        nn = ni - t;
        rn = (ri >> 1) + (SW'(1) << (60 - 2 * k));
      end else begin
        nn = ni;
        rn = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= vi;
        sn[k] <= nn;
        sr[k] <= rn;
        sc[k] <= ci;
      end
    end
  end

  // Dividend setup: |a| << (FB+15), plus half the divisor for rounding
  logic [30:0]   pd;
  logic [NW-1:0] pn [3];
  carry_t        pc;
  logic          pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sv[SQ-1];
      pc <= sc[SQ-1];
      pd <= sr[SQ-1][30:0];
      for (int c = 0; c < 3; c++) begin
        pn[c] <= (NW'(sc[SQ-1].mag[c]) << (FB + 15)) + NW'(sr[SQ-1][30:1]);
      end
    end
  end

  // Restoring division, most significant quotient bit first
  logic [NW-1:0] dr [QB][3];
  logic [QB-1:0] dq [QB][3];
  logic [30:0]   dd [QB];
  carry_t        dc [QB];
  logic          dv [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [NW-1:0] ri [3];
    logic [QB-1:0] qi [3];
    logic [NW-1:0] rn [3];
    logic [QB-1:0] qn [3];
    logic [NW-1:0] dsh;
    logic [30:0]   di;
    carry_t        ci;
    logic          vi;

    if (j == 0) begin : g_first
      assign ri = pn;
      assign qi = '{default: '0};
      assign di = pd;
      assign ci = pc;
      assign vi = pv;
    end else begin : g_rest
      assign ri = dr[j-1];
      assign qi = dq[j-1];
      assign di = dd[j-1];
      assign ci = dc[j-1];
      assign vi = dv[j-1];
    end

    assign dsh = NW'(di) << (QB - 1 - j);

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (ri[c] >= dsh) begin
          rn[c] = ri[c] - dsh;
          qn[c] = {qi[c][QB-2:0], 1'b1};
        end else begin
          rn[c] = ri[c];
          qn[c] = {qi[c][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= vi;
        dr[j] <= rn;
        dq[j] <= qn;
        dd[j] <= di;
        dc[j] <= ci;
      end
    end
  end

  // Restore signs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QB-1];
      ux <= dc[QB-1].sgn[0] ? -CW'(dq[QB-1][0]) : CW'(dq[QB-1][0]);
      uy <= dc[QB-1].sgn[1] ? -CW'(dq[QB-1][1]) : CW'(dq[QB-1][1]);
      uz <= dc[QB-1].sgn[2] ? -CW'(dq[QB-1][2]) : CW'(dq[QB-1][2]);
      cos_out <= dc[QB-1].c;
      sin_out <= dc[QB-1].s;
      zero_out <= dc[QB-1].zero;
    end
  end

endmodule

// ===== design/aarm_matrix.sv =====
// Rodrigues matrix assembly: two multiply levels with rounding, output scaling,
// saturation and the zero-axis identity override. Depends on aarm_pkg.
module aarm_matrix #(
  parameter int FB = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [FB+1:0] ux,
  input  logic signed [FB+1:0] uy,
  input  logic signed [FB+1:0] uz,
  input  logic signed [FB+1:0] cos_in,
  input  logic signed [FB+1:0] sin_in,
  input  logic                 zero_in,
  output logic                 out_valid,
  output logic signed [17:0]   m [9],
  output logic                 zero_out
);
  import aarm_pkg::*;

  localparam int W  = FB + 3;
  localparam int PW = 2 * W;
  localparam int EW = W + 16;

  // Products: xx yy zz xy yz zx xs ys zs
  logic signed [W-1:0]  opa [9];
  logic signed [W-1:0]  opb [9];
  logic signed [PW-1:0] p1 [9];
  logic signed [W-1:0]  nc1, c1;
  logic                 v1, z1;

  assign opa = '{W'(ux), W'(uy), W'(uz), W'(ux), W'(uy), W'(uz), W'(ux), W'(uy), W'(uz)};
  assign opb = '{W'(ux), W'(uy), W'(uz), W'(uy), W'(uz), W'(ux),
                 W'(sin_in), W'(sin_in), W'(sin_in)};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      z1 <= zero_in;
      c1 <= W'(cos_in);
      nc1 <= (W'(1) <<< FB) - W'(cos_in);
      for (int k = 0; k < 9; k++) p1[k] <= opa[k] * opb[k];
    end
  end

  // Round to FB fraction bits
  logic signed [W-1:0] a2 [9];
  logic signed [W-1:0] nc2, c2;
  logic                v2, z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      z2 <= z1;
      c2 <= c1;
      nc2 <= nc1;
      for (int k = 0; k < 9; k++) begin
        a2[k] <= W'((p1[k] + (PW'(1) <<< (FB - 1))) >>> FB);
      end
    end
  end

  // Scale by (1 - cos)
  logic signed [PW-1:0] q3 [6];
  logic signed [W-1:0]  t3 [3];
  logic signed [W-1:0]  c3;
  logic                 v3, z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
      z3 <= z2;
      c3 <= c2;
      for (int k = 0; k < 6; k++) q3[k] <= a2[k] * nc2;
      for (int k = 0; k < 3; k++) t3[k] <= a2[k + 6];
    end
  end

  // Round and add the diagonal or cross term
  logic signed [W-1:0] r4 [6];
  logic signed [W-1:0] e4 [9];
  logic                v4, z4;

  always_comb begin
    for (int k = 0; k < 6; k++) r4[k] = W'((q3[k] + (PW'(1) <<< (FB - 1))) >>> FB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      z4 <= z3;
      e4[0] <= r4[0] + c3;
      e4[1] <= r4[3] + t3[2];
      e4[2] <= r4[5] - t3[1];
      e4[3] <= r4[3] - t3[2];
      e4[4] <= r4[1] + c3;
      e4[5] <= r4[4] + t3[0];
      e4[6] <= r4[5] + t3[1];
      e4[7] <= r4[4] - t3[0];
      e4[8] <= r4[2] + c3;
    end
  end

  // Rescale to Q1.16 and clamp
  logic signed [EW-1:0] s5 [9];
  logic signed [17:0]   m_next [9];

  for (genvar k = 0; k < 9; k++) begin : g_out
    if (FB > 16) begin : g_down
      assign s5[k] = (EW'(e4[k]) + (EW'(1) <<< (FB - 17))) >>> (FB - 16);
    end else begin : g_up
      assign s5[k] = EW'(e4[k]) <<< (16 - FB);
    end

    always_comb begin
      if (z4) begin
        m_next[k] = (k % 4 == 0) ? 18'(OUT_ONE) : '0;
      end else if (s5[k] > EW'(OUT_ONE)) begin
        m_next[k] = 18'(OUT_ONE);
      end else if (s5[k] < -EW'(OUT_ONE)) begin
        m_next[k] = -18'(OUT_ONE);
      end else begin
        m_next[k] = 18'(s5[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
      zero_out <= z4;
      m <= m_next;
    end
  end

endmodule

// ===== design/axis_angle_rotation_matrix.sv =====
// Top level: axis-angle to 3x3 rotation matrix, fixed point, fully pipelined.
// Depends on aarm_pkg, aarm_angle, aarm_cordic, aarm_norm and aarm_matrix.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  axis_x axis_y axis_z angle_deg
//   out      source     out_valid/out_stall  m00..m22 axis_zero
//
// One transfer per cycle in and out while no result waits on out_stall. The
// CORDIC iterations, the 31-step square root and the FRAC_BITS+1 quotient
// stages of the axis dividers set the pipeline depth.
// Reset clears the valid bits only. One enable moves every stage together; it
// drops while a result waits on out_stall, and in_stall follows it.
module axis_angle_rotation_matrix #(
  parameter int FRAC_BITS   = aarm_pkg::FRAC_BITS_DEF,
  parameter int TRIG_STAGES = aarm_pkg::TRIG_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] angle_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] m00,
  output logic signed [17:0] m01,
  output logic signed [17:0] m02,
  output logic signed [17:0] m10,
  output logic signed [17:0] m11,
  output logic signed [17:0] m12,
  output logic signed [17:0] m20,
  output logic signed [17:0] m21,
  output logic signed [17:0] m22,
  output logic               axis_zero
);
  import aarm_pkg::*;

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  axis_t axis_in, axis_a, axis_c;
  assign axis_in = '{x: axis_x, y: axis_y, z: axis_z};

  logic        va, neg_a, mir_a;
  logic [31:0] rad_a;

  aarm_angle u_angle (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .angle_deg(angle_deg),
    .axis_in(axis_in), .out_valid(va), .rad(rad_a), .neg_out(neg_a),
    .mirror_out(mir_a), .axis_out(axis_a)
  );

  logic                        vc;
  logic signed [FRAC_BITS+1:0] cos_c, sin_c;

  aarm_cordic #(.STAGES(TRIG_STAGES), .FB(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(va), .rad(rad_a), .neg_in(neg_a),
    .mirror_in(mir_a), .axis_in(axis_a), .out_valid(vc), .cos_out(cos_c),
    .sin_out(sin_c), .axis_out(axis_c)
  );

  logic                        vn, zero_n;
  logic signed [FRAC_BITS+1:0] ux, uy, uz, cos_n, sin_n;

  aarm_norm #(.FB(FRAC_BITS)) u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc), .cos_in(cos_c), .sin_in(sin_c),
    .axis_in(axis_c), .out_valid(vn), .ux(ux), .uy(uy), .uz(uz),
    .cos_out(cos_n), .sin_out(sin_n), .zero_out(zero_n)
  );

  logic signed [17:0] m [9];

  aarm_matrix #(.FB(FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst), .en(en), .in_valid(vn), .ux(ux), .uy(uy), .uz(uz),
    .cos_in(cos_n), .sin_in(sin_n), .zero_in(zero_n), .out_valid(out_valid),
    .m(m), .zero_out(axis_zero)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

endmodule

// ===== dv/axis_angle_rotation_matrix_test.sv =====
// Self-checking testbench for axis_angle_rotation_matrix: random and directed
// axis/angle transfers, each matrix predicted in fixed point and compared.
// Depends on aarm_pkg and the axis_angle_rotation_matrix RTL.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_test;
  import aarm_pkg::*;

  localparam int FB = 16;
  localparam int STAGES = 18;
  localparam int LATENCY = STAGES + FB + 46;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] ang;
    bit                 hold;   // wait for every expected matrix before sending
  } req_t;

  typedef struct {
    logic signed [17:0] m [9];
    logic               zero;
  } mat_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0;
  logic signed [31:0] angle_deg = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic axis_zero;

  req_t pending_reqs [$];
  mat_t expected_mats [$];
  int   errors = 0;

  axis_angle_rotation_matrix dut (.*);

  always #5 clk = ~clk;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return rshift(a * b, FB);
  endfunction

  function automatic logic signed [17:0] sat_q16(longint v);
    if (v > OUT_ONE) v = OUT_ONE;
    if (v < -OUT_ONE) v = -OUT_ONE;
    return v[17:0];
  endfunction

  function automatic longint unit_part(longint a, longint len);
    longint mag, q;
    mag = a < 0 ? -a : a;
    q = ((mag << (FB + 15)) + len / 2) / len;
    return a < 0 ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic mat_t rotation_of(req_t r);
    mat_t e;
    longint ax, ay, az, red, mag, x, y, z, dx, dy, c, s, nc, len;
    longint ux, uy, uz, xy, yz, zx, xs, ys, zs;
    longint unsigned rad;
    bit neg, mirror;
    ax = r.ax; ay = r.ay; az = r.az;
    if (ax == 0 && ay == 0 && az == 0) begin
      for (int i = 0; i < 9; i++) e.m[i] = (i % 4 == 0) ? 18'(OUT_ONE) : 18'(0);
      e.zero = 1;
      return e;
    end
    red = longint'(r.ang) % longint'(DEG_FULL);
    if (red < 0) red += DEG_FULL;
    if (red >= DEG_HALF) red -= DEG_FULL;
    neg = red < 0;
    mag = neg ? -red : red;
    mirror = mag > DEG_QUARTER;
    if (mirror) mag = DEG_HALF - mag;
    rad = (longint'(mag) * longint'(PI_Q44) + (64'd1 << 29)) >> 30;
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = rad;
    for (int i = 0; i < STAGES; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    c = rshift(x, 30 - FB);
    s = rshift(y, 30 - FB);
    if (mirror) c = -c;
    if (neg) s = -s;
    len = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 30);
    ux = unit_part(ax, len);
    uy = unit_part(ay, len);
    uz = unit_part(az, len);
    nc = (longint'(1) << FB) - c;
    xy = mulq(ux, uy); yz = mulq(uy, uz); zx = mulq(uz, ux);
    xs = mulq(ux, s); ys = mulq(uy, s); zs = mulq(uz, s);
    e.m[0] = sat_q16(mulq(mulq(ux, ux), nc) + c);
    e.m[1] = sat_q16(mulq(xy, nc) + zs);
    e.m[2] = sat_q16(mulq(zx, nc) - ys);
    e.m[3] = sat_q16(mulq(xy, nc) - zs);
    e.m[4] = sat_q16(mulq(mulq(uy, uy), nc) + c);
    e.m[5] = sat_q16(mulq(yz, nc) + xs);
    e.m[6] = sat_q16(mulq(zx, nc) + ys);
    e.m[7] = sat_q16(mulq(yz, nc) - xs);
    e.m[8] = sat_q16(mulq(mulq(uz, uz), nc) + c);
    e.zero = 0;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_req(int ax, int ay, int az, int ang, bit hold = 0);
    req_t r;
    r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az); r.ang = ang; r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  // driver
  int  send_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_mats.push_back(rotation_of('{axis_x, axis_y, axis_z, angle_deg, 0}));
        send_wait = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) send_wait = 0;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0 && pending_reqs[0].hold &&
                     (expected_mats.size() > 0 || out_valid)) begin
          in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          axis_x <= r.ax; axis_y <= r.ay; axis_z <= r.az; angle_deg <= r.ang;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  int recv_wait = 0;
  always @(posedge clk) begin
    mat_t e;
    logic signed [17:0] got [9];
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        if (expected_mats.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          e = expected_mats.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== e.m[i])
              report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], e.m[i]);
          if (axis_zero !== e.zero) report_mismatch("axis_zero", axis_zero, e.zero);
        end
        recv_wait = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    int big [6] = '{32767, -32768, 1, -1, 0, 12345};
    // directed: field extremes, zero axis, quadrant edges and mirror points
    queue_req(0, 0, 0, 0);
    queue_req(0, 0, 0, 32'h7fffffff);
    queue_req(32767, 0, 0, 90 << 16);
    queue_req(0, -32768, 0, -(90 << 16));
    queue_req(0, 0, 1, 180 << 16);
    queue_req(-1, 0, 0, -(180 << 16));
    queue_req(32767, 32767, 32767, 45 << 16);
    queue_req(-32768, -32768, -32768, 32'h80000000);
    queue_req(1, 1, 1, 360 << 16);
    queue_req(3, 4, 0, 32'h7fffffff);
    queue_req(-32768, 32767, 1, (90 << 16) + 1);
    queue_req(0, 1, -1, (90 << 16) - 1);
    queue_req(1, 0, 0, 270 << 16);
    queue_req(-5, 7, 11, -(720 << 16) + 3);
    queue_req(16384, -16384, 0, 1);
    queue_req(32767, 0, 0, 0, 1);
    for (int i = 0; i < 400; i++) begin
      int ax, ay, az, ang;
      case ($urandom_range(0, 5))
        0: begin ax = big[$urandom_range(0, 5)]; ay = big[$urandom_range(0, 5)];
                 az = big[$urandom_range(0, 5)]; end
        1: begin ax = $signed($urandom_range(0, 8)) - 4; ay = $signed($urandom_range(0, 8)) - 4;
                 az = $signed($urandom_range(0, 8)) - 4; end
        default: begin ax = $signed(16'($urandom)); ay = $signed(16'($urandom));
                       az = $signed(16'($urandom)); end
      endcase
      if ($urandom_range(0, 1)) ang = $urandom;
      else ang = ($signed($urandom_range(0, 1440)) - 720) << 16 | $urandom_range(0, 3);
      queue_req(ax, ay, az, ang, i == 200);
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_mats.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/aarm_pkg.sv
design/aarm_angle.sv
design/aarm_cordic.sv
design/aarm_norm.sv
design/aarm_matrix.sv
design/axis_angle_rotation_matrix.sv
dv/axis_angle_rotation_matrix_test.sv
